/* hdl/value_sorted_key_value_table_defines.svh */
// Assertion macros shared by the table RTL.
`ifndef VALUE_SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define VALUE_SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define VSKV_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vskv: invariant violated");

// Antecedent implies consequent in the same cycle.
`define VSKV_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vskv: same-cycle implication violated");

// Antecedent implies consequent in the next cycle.
`define VSKV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vskv: next-cycle implication violated");

`endif

/* hdl/vskv_pkg.sv */
`default_nettype none

package vskv_pkg;

   localparam int DATA_W  = 32;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_RANK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MERGE,
      S_FLUSH,
      S_RANK,
      S_RANK_RD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } entry_type;

   // Signed compare a >= b.
   function automatic logic value_ge(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      return $signed(a) >= $signed(b);
   endfunction

endpackage

`default_nettype wire

/* hdl/vskv_if.sv */
`default_nettype none

interface vskv_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            command;
   logic signed [vskv_pkg::DATA_W-1:0]    key;
   logic signed [vskv_pkg::DATA_W-1:0]    value;
   logic [vskv_pkg::RANK_W-1:0]           rank;

   modport source (output valid, command, key, value, rank, input ready);
   modport sink   (input valid, command, key, value, rank, output ready);
endinterface

interface vskv_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            status;
   logic signed [vskv_pkg::DATA_W-1:0]    out_key;
   logic signed [vskv_pkg::DATA_W-1:0]    out_value;
   logic [vskv_pkg::COUNT_W-1:0]          entry_count;

   modport source (output valid, status, out_key, out_value, entry_count, input ready);
   modport sink   (input valid, status, out_key, out_value, entry_count, output ready);
endinterface

`default_nettype wire

/* hdl/vskv_mem.sv */
`default_nettype none

module vskv_mem #(
   parameter int  DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [AddrW-1:0]          wr_addr,
   input  vskv_pkg::entry_type      wr_data,
   input  wire [AddrW-1:0]          rd_addr,
   output vskv_pkg::entry_type      rd_data
);

   vskv_pkg::entry_type entry_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data <= entry_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/value_sorted_key_value_table.sv */
// Value-ordered key/value table, largest value first.
// Requests arrive on req_ch (valid/ready) carrying command, key, value and rank;
// every request yields exactly one response on rsp_ch with status, out_key,
// out_value and the entry count after the operation.
// Entries live in a single-port-read, single-port-write memory. A small
// sequencer streams the stored entries through one key compare and one signed
// value compare, one entry per cycle, rewriting the list in place in a merge pass.
// Put (table not full) and remove run one merge pass over the stored entries;
// a put into a full table runs a key search pass first and is refused when the
// key is absent, else replaces the key in a merge pass; get runs one search
// pass and a rank read makes one direct memory read.
// One request is worked on at a time; req_ch.ready is high only while idle.
// The response sits in an output register, so the next request is accepted
// while a response waits; the sequencer holds its finished result only if
// the output register is still occupied when the next one completes.
// Synchronous reset empties the table and drops any pending response; the
// memory itself is not cleared, as entries at or past the count are never used.

`default_nettype none
`include "value_sorted_key_value_table_defines.svh"

module value_sorted_key_value_table #(
   parameter int CAPACITY = 16
) (
   input wire           clock,
   input wire           reset,
   vskv_req_if.sink     req_ch,
   vskv_rsp_if.source   rsp_ch
);

   localparam int IdxW = $clog2(CAPACITY);
   localparam int OccW = $clog2(CAPACITY + 1);
   localparam int CmpW = (OccW > vskv_pkg::RANK_W) ? OccW : vskv_pkg::RANK_W;

   vskv_pkg::state_type  state_ff, state_in;
   vskv_pkg::cmd_type    cmd_ff, cmd_in;
   logic [vskv_pkg::DATA_W-1:0] key_ff, key_in;
   logic [vskv_pkg::DATA_W-1:0] value_ff, value_in;
   logic [vskv_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic [OccW-1:0]      occ_ff, occ_in;
   logic [OccW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [OccW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic                 data_vld_ff, data_vld_in;
   logic                 found_ff, found_in;
   logic                 inserted_ff, inserted_in;
   logic                 carry_vld_ff, carry_vld_in;
   vskv_pkg::entry_type  carry_ff, carry_in;
   vskv_pkg::status_type res_status_ff, res_status_in;
   logic [vskv_pkg::DATA_W-1:0] res_key_ff, res_key_in;
   logic [vskv_pkg::DATA_W-1:0] res_val_ff, res_val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   vskv_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [vskv_pkg::DATA_W-1:0] rsp_key_ff, rsp_key_in;
   logic [vskv_pkg::DATA_W-1:0] rsp_val_ff, rsp_val_in;
   logic [vskv_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                 rsp_load;
   logic                 mem_wr_en;
   logic [IdxW-1:0]      mem_wr_addr;
   vskv_pkg::entry_type  mem_wr_data;
   logic [IdxW-1:0]      mem_rd_addr;
   vskv_pkg::entry_type  mem_rd_data;
   vskv_pkg::entry_type  new_entry;

   vskv_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign new_entry = '{key: key_ff, value: value_ff};

   assign req_ch.ready       = (state_ff == vskv_pkg::S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.out_key     = rsp_key_ff;
   assign rsp_ch.out_value   = rsp_val_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rank_in       = rank_ff;
      occ_in        = occ_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      data_vld_in   = 1'b0;
      found_in      = found_ff;
      inserted_in   = inserted_ff;
      carry_vld_in  = carry_vld_ff;
      carry_in      = carry_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_load      = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wr_ptr_ff[IdxW-1:0];
      mem_wr_data   = carry_ff;
      mem_rd_addr   = rd_ptr_ff[IdxW-1:0];

      unique case (state_ff)
         vskv_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in        = vskv_pkg::cmd_type'(req_ch.command);
               key_in        = req_ch.key;
               value_in      = req_ch.value;
               rank_in       = req_ch.rank;
               rd_ptr_in     = '0;
               wr_ptr_in     = '0;
               found_in      = 1'b0;
               inserted_in   = 1'b0;
               carry_vld_in  = 1'b0;
               res_status_in = vskv_pkg::ST_OK;
               res_key_in    = '0;
               res_val_in    = '0;
               unique case (vskv_pkg::cmd_type'(req_ch.command))
                  vskv_pkg::CMD_PUT: begin
                     // a full table must first learn whether the key is present
                     state_in = (occ_ff == OccW'(CAPACITY)) ? vskv_pkg::S_SCAN
                                                            : vskv_pkg::S_MERGE;
                  end
                  vskv_pkg::CMD_REMOVE: state_in = vskv_pkg::S_MERGE;
                  vskv_pkg::CMD_GET:    state_in = vskv_pkg::S_SCAN;
                  vskv_pkg::CMD_RANK:   state_in = vskv_pkg::S_RANK;
                  default:              state_in = vskv_pkg::S_IDLE;
               endcase
            end
         end

         vskv_pkg::S_SCAN: begin
            if (rd_ptr_ff < occ_ff) begin
               data_vld_in = 1'b1;
               rd_ptr_in   = rd_ptr_ff + 1'b1;
            end
            if (data_vld_ff && (mem_rd_data.key == key_ff) && !found_ff) begin
               found_in   = 1'b1;
               res_val_in = mem_rd_data.value;
            end
            if (!data_vld_ff && (rd_ptr_ff == occ_ff)) begin
               if (cmd_ff == vskv_pkg::CMD_GET) begin
                  if (!found_ff) begin
                     res_status_in = vskv_pkg::ST_ABSENT;
                  end
                  state_in = vskv_pkg::S_DONE;
               end else if (found_ff) begin
                  // key present: replace it in a merge pass
                  rd_ptr_in  = '0;
                  found_in   = 1'b0;
                  res_val_in = '0;
                  state_in   = vskv_pkg::S_MERGE;
               end else begin
                  res_status_in = vskv_pkg::ST_FULL;
                  state_in      = vskv_pkg::S_DONE;
               end
            end
         end

         vskv_pkg::S_MERGE: begin
            if (rd_ptr_ff < occ_ff) begin
               data_vld_in = 1'b1;
               rd_ptr_in   = rd_ptr_ff + 1'b1;
            end
            if (data_vld_ff) begin
               if (mem_rd_data.key == key_ff) begin
                  // drop the matching entry
                  found_in = 1'b1;
               end else if ((cmd_ff == vskv_pkg::CMD_PUT) && !inserted_ff &&
                            !vskv_pkg::value_ge(mem_rd_data.value, value_ff)) begin
                  mem_wr_en    = 1'b1;
                  mem_wr_data  = new_entry;
                  wr_ptr_in    = wr_ptr_ff + 1'b1;
                  carry_in     = mem_rd_data;
                  carry_vld_in = 1'b1;
                  inserted_in  = 1'b1;
               end else if (carry_vld_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = carry_ff;
                  wr_ptr_in   = wr_ptr_ff + 1'b1;
                  carry_in    = mem_rd_data;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data;
                  wr_ptr_in   = wr_ptr_ff + 1'b1;
               end
            end else if (rd_ptr_ff == occ_ff) begin
               state_in = vskv_pkg::S_FLUSH;
            end
         end

         vskv_pkg::S_FLUSH: begin
            // drain the carried entry, or append the new pair at the tail
            if (carry_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = carry_ff;
               occ_in      = wr_ptr_ff + 1'b1;
            end else if ((cmd_ff == vskv_pkg::CMD_PUT) && !inserted_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = new_entry;
               occ_in      = wr_ptr_ff + 1'b1;
            end else begin
               occ_in = wr_ptr_ff;
            end
            carry_vld_in = 1'b0;
            if ((cmd_ff == vskv_pkg::CMD_REMOVE) && !found_ff) begin
               res_status_in = vskv_pkg::ST_ABSENT;
            end
            state_in = vskv_pkg::S_DONE;
         end

         vskv_pkg::S_RANK: begin
            mem_rd_addr = IdxW'(rank_ff);
            state_in    = vskv_pkg::S_RANK_RD;
         end

         vskv_pkg::S_RANK_RD: begin
            if (CmpW'(rank_ff) < CmpW'(occ_ff)) begin
               res_key_in = mem_rd_data.key;
               res_val_in = mem_rd_data.value;
            end else begin
               res_status_in = vskv_pkg::ST_ABSENT;
            end
            state_in = vskv_pkg::S_DONE;
         end

         vskv_pkg::S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_val_in    = res_val_ff;
               rsp_count_in  = vskv_pkg::COUNT_W'(occ_ff);
               state_in      = vskv_pkg::S_IDLE;
            end
         end

         default: state_in = vskv_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vskv_pkg::S_IDLE;
         occ_ff       <= '0;
         data_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         inserted_ff  <= 1'b0;
         carry_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         data_vld_ff  <= data_vld_in;
         found_ff     <= found_in;
         inserted_ff  <= inserted_in;
         carry_vld_ff <= carry_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rank_ff       <= rank_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `VSKV_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= OccW'(CAPACITY))
   `VSKV_ASSERT_IMPLY(a_write_behind_read, clock, reset, (state_ff == vskv_pkg::S_MERGE) && mem_wr_en, wr_ptr_ff < rd_ptr_ff)
   `VSKV_ASSERT_IMPLY(a_idle_no_carry, clock, reset, state_ff == vskv_pkg::S_IDLE, !carry_vld_ff)
   `VSKV_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, state_ff != vskv_pkg::S_IDLE)
   `VSKV_ASSERT_IMPLY(a_full_only_when_full, clock, reset, rsp_load && (res_status_ff == vskv_pkg::ST_FULL), occ_ff == OccW'(CAPACITY))

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int CAPACITY      = 16;
   localparam int KEY_POOL_SIZE = 20;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 105;
   localparam int MAX_GAP       = 12;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic signed [vskv_pkg::DATA_W-1:0] MOST_NEGATIVE =
      {1'b1, {(vskv_pkg::DATA_W-1){1'b0}}};
   localparam logic signed [vskv_pkg::DATA_W-1:0] MOST_POSITIVE =
      {1'b0, {(vskv_pkg::DATA_W-1){1'b1}}};

   typedef struct {
      vskv_pkg::status_type                status;
      logic signed [vskv_pkg::DATA_W-1:0]  out_key;
      logic signed [vskv_pkg::DATA_W-1:0]  out_value;
      logic [vskv_pkg::COUNT_W-1:0]        entry_count;
   } table_response_type;

   // Shadow copy of the table, kept in value order, plus the responses it owes.
   class table_shadow_type;
      logic signed [vskv_pkg::DATA_W-1:0] keys [CAPACITY];
      logic signed [vskv_pkg::DATA_W-1:0] values [CAPACITY];
      int                       held = 0;
      table_response_type       pending_responses [$];
      int unsigned              mismatches = 0;
      int unsigned              command_count [4] = '{0, 0, 0, 0};
      int unsigned              full_count = 0;
      int unsigned              absent_count = 0;

      function int position_of(logic signed [vskv_pkg::DATA_W-1:0] k);
         for (int p = 0; p < held; p++)
            if (keys[p] == k)
               return p;
         return held;
      endfunction

      function void drop_at(int p);
         for (int i = p; i + 1 < held; i++) begin
            keys[i]   = keys[i + 1];
            values[i] = values[i + 1];
         end
         held--;
      endfunction

      function void apply_request(vskv_pkg::cmd_type cmd,
                                  logic signed [vskv_pkg::DATA_W-1:0] k,
                                  logic signed [vskv_pkg::DATA_W-1:0] v,
                                  logic [vskv_pkg::RANK_W-1:0] r);
         table_response_type rsp;
         int                 p;
         rsp.status    = vskv_pkg::ST_OK;
         rsp.out_key   = '0;
         rsp.out_value = '0;
         command_count[cmd]++;
         case (cmd)
            vskv_pkg::CMD_PUT: begin
               p = position_of(k);
               if (p < held)
                  drop_at(p);
               if (held >= CAPACITY) begin
                  rsp.status = vskv_pkg::ST_FULL;
               end else begin
                  // place after every entry with a value greater or equal
                  p = 0;
                  while (p < held && values[p] >= v)
                     p++;
                  for (int i = held; i > p; i--) begin
                     keys[i]   = keys[i - 1];
                     values[i] = values[i - 1];
                  end
                  keys[p]   = k;
                  values[p] = v;
                  held++;
               end
            end
            vskv_pkg::CMD_REMOVE: begin
               p = position_of(k);
               if (p < held)
                  drop_at(p);
               else
                  rsp.status = vskv_pkg::ST_ABSENT;
            end
            vskv_pkg::CMD_GET: begin
               p = position_of(k);
               if (p < held)
                  rsp.out_value = values[p];
               else
                  rsp.status = vskv_pkg::ST_ABSENT;
            end
            default: begin
               if (int'(r) < held) begin
                  rsp.out_key   = keys[r];
                  rsp.out_value = values[r];
               end else begin
                  rsp.status = vskv_pkg::ST_ABSENT;
               end
            end
         endcase
         if (rsp.status == vskv_pkg::ST_FULL)
            full_count++;
         if (rsp.status == vskv_pkg::ST_ABSENT)
            absent_count++;
         rsp.entry_count = vskv_pkg::COUNT_W'(held);
         pending_responses.push_back(rsp);
      endfunction

      function void compare_response(logic [1:0] st,
                                     logic signed [vskv_pkg::DATA_W-1:0] k,
                                     logic signed [vskv_pkg::DATA_W-1:0] v,
                                     logic [vskv_pkg::COUNT_W-1:0] cnt);
         table_response_type want;
         if (pending_responses.size() == 0) begin
            $display("%0t: response with none expected, actual status %0d key %0d value %0d",
                     $time, st, k, v);
            mismatches++;
            return;
         end
         want = pending_responses.pop_front();
         if (st !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
            mismatches++;
         end
         if (k !== want.out_key) begin
            $display("%0t: out_key expected %0d, actual %0d", $time, want.out_key, k);
            mismatches++;
         end
         if (v !== want.out_value) begin
            $display("%0t: out_value expected %0d, actual %0d", $time, want.out_value, v);
            mismatches++;
         end
         if (cnt !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, actual %0d", $time, want.entry_count,
                     cnt);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bit          sender_eager = 1'b0;
   bit          receiver_eager = 1'b0;
   bit          filling = 1'b1;
   logic        hold_responses = 1'b0;
   int unsigned cycle_count = 0;

   logic signed [vskv_pkg::DATA_W-1:0] key_pool [KEY_POOL_SIZE];
   table_shadow_type                   shadow = new();

   vskv_req_if req_ch ();
   vskv_rsp_if rsp_ch ();

   value_sorted_key_value_table #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one request and hold it until the table takes it.
   task automatic send_request(vskv_pkg::cmd_type cmd,
                               logic signed [vskv_pkg::DATA_W-1:0] k,
                               logic signed [vskv_pkg::DATA_W-1:0] v,
                               logic [vskv_pkg::RANK_W-1:0] r);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.key     <= k;
      req_ch.value   <= v;
      req_ch.rank    <= r;
      do @(posedge clock); while (!req_ch.ready);
      shadow.apply_request(cmd, k, v, r);
   endtask

   function automatic vskv_pkg::cmd_type pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 60 : 25))
         return vskv_pkg::CMD_PUT;
      if (roll < (filling ? 70 : 70))
         return vskv_pkg::CMD_REMOVE;
      if (roll < 85)
         return vskv_pkg::CMD_GET;
      return vskv_pkg::CMD_RANK;
   endfunction

   function automatic logic signed [vskv_pkg::DATA_W-1:0] pick_key();
      if ($urandom_range(0, 9) == 0)
         return $urandom;
      return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
   endfunction

   function automatic logic signed [vskv_pkg::DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return int'($urandom_range(0, 6)) - 3;   // narrow range forces ties
      if (roll < 8)
         return $urandom;
      case ($urandom_range(0, 3))
         0:       return MOST_NEGATIVE;
         1:       return MOST_POSITIVE;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   initial begin : response_sink
      int pause;
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_responses && !hold_done) begin
            pause     = LONG_HOLD;
            hold_done = 1'b1;
         end else begin
            pause = receiver_eager ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (pause > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         shadow.compare_response(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_value,
                                 rsp_ch.entry_count);
      end
   end

   initial begin : stimulus
      int                            next_key;
      logic [vskv_pkg::RANK_W-1:0]   r;
      vskv_pkg::cmd_type             cmd;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= vskv_pkg::CMD_PUT;
      req_ch.key     <= '0;
      req_ch.value   <= '0;
      req_ch.rank    <= '0;
      key_pool[0] = MOST_NEGATIVE;
      key_pool[1] = MOST_POSITIVE;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table: every lookup misses
      send_request(vskv_pkg::CMD_RANK, '0, '0, 4'd15);
      send_request(vskv_pkg::CMD_GET, '0, '0, '0);
      send_request(vskv_pkg::CMD_REMOVE, '0, '0, '0);
      send_request(vskv_pkg::CMD_PUT, MOST_POSITIVE, '0, '0);
      send_request(vskv_pkg::CMD_PUT, MOST_NEGATIVE, MOST_NEGATIVE, '0);
      // new largest value with two entries held goes to the head
      send_request(vskv_pkg::CMD_PUT, 1, MOST_POSITIVE, '0);
      // equal value lands behind the earlier one
      send_request(vskv_pkg::CMD_PUT, 2, MOST_POSITIVE, '0);
      send_request(vskv_pkg::CMD_PUT, MOST_NEGATIVE, -5, '0);
      send_request(vskv_pkg::CMD_GET, MOST_NEGATIVE, '0, '0);
      send_request(vskv_pkg::CMD_GET, 3, '0, '0);
      send_request(vskv_pkg::CMD_REMOVE, 2, '0, '0);
      send_request(vskv_pkg::CMD_RANK, '0, '0, 4'd0);
      send_request(vskv_pkg::CMD_RANK, '0, '0, 4'd2);
      next_key = 1000;
      while (shadow.held < CAPACITY) begin
         send_request(vskv_pkg::CMD_PUT, next_key, int'($urandom_range(0, 8)) - 4, '0);
         next_key++;
      end
      // full: a new key is refused, an existing key is replaced
      send_request(vskv_pkg::CMD_PUT, next_key, 7, '0);
      send_request(vskv_pkg::CMD_PUT, 1000, MOST_NEGATIVE, '0);
      send_request(vskv_pkg::CMD_RANK, '0, '0, 4'd15);

      for (int phase = 0; phase < PHASES; phase++) begin
         filling        = ((phase / 2) % 2) == 0;
         sender_eager   = (phase % 4) == 1 || (phase % 4) == 3;
         receiver_eager = (phase % 4) >= 2;
         if (phase == 1)
            hold_responses <= 1'b1;
         repeat (PHASE_ITEMS) begin
            cmd = pick_command();
            if ($urandom_range(0, 1) == 0 && shadow.held > 0)
               r = vskv_pkg::RANK_W'($urandom_range(0, shadow.held - 1));
            else
               r = vskv_pkg::RANK_W'($urandom_range(0, 15));
            send_request(cmd, pick_key(),
                         cmd == vskv_pkg::CMD_PUT ? pick_value() : $urandom, r);
         end
      end
      req_ch.valid <= 1'b0;

      while (shadow.pending_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d put, %0d remove, %0d get, %0d rank read",
               shadow.command_count.sum(), shadow.command_count[vskv_pkg::CMD_PUT],
               shadow.command_count[vskv_pkg::CMD_REMOVE],
               shadow.command_count[vskv_pkg::CMD_GET],
               shadow.command_count[vskv_pkg::CMD_RANK]);
      $display("%0d puts refused on a full table, %0d absent results, %0d mismatches",
               shadow.full_count, shadow.absent_count, shadow.mismatches);
      if (shadow.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
